// ----- sv/lpht_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared codes and widths for the linear-probe hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int KEY_W   = 64;
    localparam int DATA_W  = 64;
    localparam int SLOT_W  = 6;
    localparam int HASH_W  = 32;
    localparam int MCNT_W  = 5;

    typedef enum logic [1:0] {
        MODE_PUT    = 2'd0,
        MODE_GET    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_MISSING = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_RSVD    = 2'd3
    } t_status;

endpackage

// ----- sv/lpht_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/linear_probe_hash_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Open-addressing key/value table with linear probing, entries in one RAM.
// ----------------------------------------------------------------------------
//  channel   | signals                                  | handshake
//  ----------+------------------------------------------+---------------------
//  request   | i_mode, i_key, i_value_in                | start && !busy
//  result    | o_status, o_value_out, o_slot            | o_valid, one cycle
//
//  a put refused by occupancy, or mode 3, answers in the cycle after the request
//  other requests: hash states H2 and H3, then the multiply, quotient and
//  remainder steps of the modulo when TABLE_SIZE is not a power of two, then
//  one RAM read per probe cycle, checking at most MAX_PROBES slots; the single
//  RAM read port sets the probe rate
//  after reset a clearing pass over all TABLE_SIZE entries holds busy high
//  the receiver cannot stall; results are never held back
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE  = 64,
    parameter int MAX_PROBES  = 8,
    parameter int VALUE_WIDTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_mode,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [DATA_W-1:0] i_value_in,
    output logic              o_valid,
    output logic [1:0]        o_status,
    output logic [DATA_W-1:0] o_value_out,
    output logic [SLOT_W-1:0] o_slot
);

    localparam int  ADDR_W  = $clog2(TABLE_SIZE);
    localparam int  CNT_W   = $clog2(TABLE_SIZE / 2 + 1);
    localparam int  PC_W    = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
    localparam int  WORD_W  = 1 + KEY_W + VALUE_WIDTH;
    localparam bit  IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_SIZE - 1);
    localparam logic [ADDR_W-1:0] SIZE_LOW  = ADDR_W'(TABLE_SIZE);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(TABLE_SIZE / 2);
    localparam logic [PC_W-1:0]   LAST_PRB  = PC_W'(MAX_PROBES - 1);

    localparam logic [2*HASH_W-1:0] RECIP_W =
        ((64'd1 << HASH_W) * ((64'd1 << ADDR_W) - 64'(TABLE_SIZE))) / 64'(TABLE_SIZE)
        + 64'd1;
    localparam logic [HASH_W-1:0]   RECIP     = RECIP_W[HASH_W-1:0];
    localparam logic [MCNT_W-1:0]   MSTEP_MUL = MCNT_W'(0);
    localparam logic [MCNT_W-1:0]   MSTEP_QUO = MCNT_W'(1);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_H2    = 6'b000100,
        ST_H3    = 6'b001000,
        ST_MOD   = 6'b010000,
        ST_PROBE = 6'b100000
    } t_state;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;

    logic [KEY_W-1:0]       r_key, n_key;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic [KEY_W-1:0]       r_h, n_h;
    logic [MCNT_W-1:0]      r_mcnt, n_mcnt;
    logic [ADDR_W-1:0]      r_iss_addr, n_iss_addr;
    logic [ADDR_W-1:0]      r_chk_addr, n_chk_addr;
    logic                   r_pend, n_pend;
    logic [PC_W-1:0]        r_chk_cnt, n_chk_cnt;
    logic [ADDR_W-1:0]      r_clr_addr, n_clr_addr;
    logic [CNT_W-1:0]       r_count, n_count;

    logic              r_valid, n_valid;
    t_status           r_status, n_status;
    logic [DATA_W-1:0] r_vout, n_vout;
    logic [SLOT_W-1:0] r_slot, n_slot;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    logic                   rd_used;
    logic [KEY_W-1:0]       rd_key;
    logic [VALUE_WIDTH-1:0] rd_val;
    logic                   key_eq;
    logic                   hit;

    logic [KEY_W-1:0]    h1;
    logic [KEY_W-1:0]    h2_mul;
    logic [KEY_W-1:0]    h2;
    logic [KEY_W-1:0]    h3_add;
    logic [KEY_W-1:0]    h3;
    logic [2*HASH_W-1:0] mod_prod;
    logic [HASH_W-1:0]   mod_t1;
    logic [HASH_W-1:0]   mod_sum;
    logic [HASH_W-1:0]   mod_q;
    logic [ADDR_W-1:0]   mod_rem;
    logic [ADDR_W-1:0]   iss_next;
    logic [SLOT_W-1:0]   chk_slot;

    lpht_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_iss_addr),
        .o_rdata (ram_rdata)
    );

    assign {rd_used, rd_key, rd_val} = ram_rdata;
    assign key_eq = (rd_key == r_key);
    assign hit    = (r_mode == MODE_PUT) ? (!rd_used || key_eq) : (rd_used && key_eq);

    // wang 64-to-32 shift hash split over the idle, H2 and H3 states
    assign h1     = ((~i_key) + (i_key << 18)) ^ (((~i_key) + (i_key << 18)) >> 31);
    assign h2_mul = r_h + (r_h << 2) + (r_h << 4);
    assign h2     = h2_mul ^ (h2_mul >> 11);
    assign h3_add = r_h + (r_h << 6);
    assign h3     = h3_add ^ (h3_add >> 22);

    // modulo the table size by reciprocal multiplication
    assign mod_prod = (2*HASH_W)'(r_h[HASH_W-1:0]) * (2*HASH_W)'(RECIP);
    assign mod_t1   = r_h[KEY_W-1:HASH_W];
    assign mod_sum  = mod_t1 + ((r_h[HASH_W-1:0] - mod_t1) >> 1);
    assign mod_q    = mod_sum >> (ADDR_W - 1);
    assign mod_rem  = r_h[ADDR_W-1:0] - r_h[HASH_W +: ADDR_W] * SIZE_LOW;

    assign iss_next = (r_iss_addr == LAST_ADDR) ? '0 : r_iss_addr + 1'b1;

    generate
        if (ADDR_W >= SLOT_W) begin : g_slot_cut
            assign chk_slot = r_chk_addr[SLOT_W-1:0];
        end else begin : g_slot_ext
            assign chk_slot = {{(SLOT_W - ADDR_W){1'b0}}, r_chk_addr};
        end
    endgenerate

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_key      = r_key;
        n_val      = r_val;
        n_h        = r_h;
        n_mcnt     = r_mcnt;
        n_iss_addr = r_iss_addr;
        n_chk_addr = r_chk_addr;
        n_pend     = r_pend;
        n_chk_cnt  = r_chk_cnt;
        n_clr_addr = r_clr_addr;
        n_count    = r_count;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_vout     = r_vout;
        n_slot     = r_slot;
        ram_we     = 1'b0;
        ram_waddr  = r_chk_addr;
        ram_wdata  = '0;

        case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_mode = t_mode'(i_mode);
                    n_key  = i_key;
                    n_val  = i_value_in[VALUE_WIDTH-1:0];
                    n_h    = h1;
                    n_vout = '0;
                    n_slot = '0;
                    if (t_mode'(i_mode) == MODE_NONE) begin
                        n_valid  = 1'b1;
                        n_status = STAT_OK;
                    end else if (t_mode'(i_mode) == MODE_PUT && r_count >= FULL_CNT) begin
                        n_valid  = 1'b1;
                        n_status = STAT_FULL;
                    end else begin
                        n_state = ST_H2;
                    end
                end
            end
            ST_H2: begin
                n_h     = h2;
                n_state = ST_H3;
            end
            ST_H3: begin
                n_pend    = 1'b0;
                n_chk_cnt = '0;
                if (IS_POW2) begin
                    n_iss_addr = h3[ADDR_W-1:0];
                    n_state    = ST_PROBE;
                end else begin
                    n_h     = {{(KEY_W - HASH_W){1'b0}}, h3[HASH_W-1:0]};
                    n_mcnt  = '0;
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                n_mcnt = r_mcnt + 1'b1;
                case (r_mcnt)
                    MSTEP_MUL: begin
                        n_h = {mod_prod[2*HASH_W-1:HASH_W], r_h[HASH_W-1:0]};
                    end
                    MSTEP_QUO: begin
                        n_h = {mod_q, r_h[HASH_W-1:0]};
                    end
                    default: begin
                        n_iss_addr = mod_rem;
                        n_state    = ST_PROBE;
                    end
                endcase
            end
            ST_PROBE: begin
                n_iss_addr = iss_next;
                n_chk_addr = r_iss_addr;
                n_pend     = 1'b1;
                if (r_pend) begin
                    n_chk_cnt = r_chk_cnt + 1'b1;
                    if (hit || r_chk_cnt == LAST_PRB) begin
                        n_state = ST_IDLE;
                        n_valid = 1'b1;
                    end
                    if (hit) begin
                        n_status = STAT_OK;
                        n_slot   = chk_slot;
                        case (r_mode)
                            MODE_PUT: begin
                                ram_we    = 1'b1;
                                ram_wdata = {1'b1, r_key, r_val};
                                n_count   = r_count + 1'b1;
                            end
                            MODE_REMOVE: begin
                                ram_we = 1'b1;
                                if (r_count != '0) begin
                                    n_count = r_count - 1'b1;
                                end
                            end
                            default: begin
                                n_vout = DATA_W'(rd_val);
                            end
                        endcase
                    end else if (r_chk_cnt == LAST_PRB) begin
                        n_status = (r_mode == MODE_PUT) ? STAT_FULL : STAT_MISSING;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_count    <= '0;
            r_valid    <= 1'b0;
            r_pend     <= 1'b0;
            r_chk_cnt  <= '0;
            r_mcnt     <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_count    <= n_count;
            r_valid    <= n_valid;
            r_pend     <= n_pend;
            r_chk_cnt  <= n_chk_cnt;
            r_mcnt     <= n_mcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_key      <= n_key;
        r_val      <= n_val;
        r_h        <= n_h;
        r_iss_addr <= n_iss_addr;
        r_chk_addr <= n_chk_addr;
        r_status   <= n_status;
        r_vout     <= n_vout;
        r_slot     <= n_slot;
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_value_out = r_vout;
    assign o_slot      = r_slot;

endmodule

// ----- sv/lpht_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks on the linear-probe hash table, bound to the top level.
// ----------------------------------------------------------------------------
module lpht_checker
    import lpht_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input logic [1:0]        o_status,
    input logic [DATA_W-1:0] o_value_out,
    input logic [SLOT_W-1:0] o_slot
);

    // a request is either answered next cycle or keeps the block busy
    a_req_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("request neither answered nor in progress");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STAT_FULL) |-> (o_slot == '0 && o_value_out == '0))
        else $error("full result carries slot or value");

    a_missing_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STAT_MISSING) |-> (o_slot == '0 && o_value_out == '0))
        else $error("missing result carries slot or value");

endmodule

bind linear_probe_hash_table_top lpht_checker u_lpht_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_status    (o_status),
    .o_value_out (o_value_out),
    .o_slot      (o_slot)
);

// ----- dv/linear_probe_hash_table_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top_test
// Self-checking test of the linear-probe hash table. Requests go in through
// start/busy in random bursts. A shadow copy of the table predicts status,
// value and slot for each accepted request. Every strobed result is checked
// against the oldest prediction. Directed tests cover the empty table,
// extreme keys and values, wraparound, the probe limit and the half-occupancy
// limit. A long random mix of clustered and random keys follows.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top_test;
    import lpht_pkg::*;

    localparam int TABLE_SIZE  = 64;
    localparam int MAX_PROBES  = 8;
    localparam int VALUE_WIDTH = 64;
    localparam int RANDOM_REQS = 380;

    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] value;
        logic [SLOT_W-1:0] slot;
    } t_answer;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        i_mode = MODE_NONE;
    logic [KEY_W-1:0]  i_key = '0;
    logic [DATA_W-1:0] i_value_in = '0;
    logic              o_valid;
    logic [1:0]        o_status;
    logic [DATA_W-1:0] o_value_out;
    logic [SLOT_W-1:0] o_slot;

    bit                shadow_used [TABLE_SIZE];
    logic [KEY_W-1:0]  shadow_key [TABLE_SIZE];
    logic [DATA_W-1:0] shadow_value [TABLE_SIZE];
    int unsigned       shadow_count;

    t_answer           pending_answers [$];
    t_answer           oldest_answer;
    int                mismatches;
    int                burst_left;

    linear_probe_hash_table_top #(
        .TABLE_SIZE  (TABLE_SIZE),
        .MAX_PROBES  (MAX_PROBES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_key       (i_key),
        .i_value_in  (i_value_in),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_value_out (o_value_out),
        .o_slot      (o_slot)
    );

    always #1 i_clk = ~i_clk;

    function automatic int unsigned home_slot(logic [KEY_W-1:0] k);
        logic [63:0] h;
        h = ~k + (k << 18);
        h = h ^ (h >> 31);
        h = h * 64'd21;
        h = h ^ (h >> 11);
        h = h + (h << 6);
        h = h ^ (h >> 22);
        return h[31:0] % TABLE_SIZE;
    endfunction

    function automatic t_answer apply_table_op(t_mode mode, logic [KEY_W-1:0] key,
                                               logic [DATA_W-1:0] val);
        t_answer     ans;
        int unsigned s;
        int unsigned at;
        bit          hit;
        ans.status = STAT_OK;
        ans.value  = '0;
        ans.slot   = '0;
        hit = 1'b0;
        at  = 0;
        s   = home_slot(key);
        case (mode)
            MODE_PUT: begin
                if (shadow_count < TABLE_SIZE / 2) begin
                    for (int i = 0; i < MAX_PROBES; i++) begin
                        if (!hit) begin
                            if (!shadow_used[s] || shadow_key[s] == key)
                                hit = 1'b1;
                            else
                                s = (s + 1) % TABLE_SIZE;
                        end
                    end
                end
                if (hit) begin
                    shadow_used[s]  = 1'b1;
                    shadow_key[s]   = key;
                    shadow_value[s] = val;
                    shadow_count++;
                    ans.slot = SLOT_W'(s);
                end else begin
                    ans.status = STAT_FULL;
                end
            end
            MODE_GET, MODE_REMOVE: begin
                for (int i = 0; i < MAX_PROBES; i++) begin
                    if (!hit && shadow_used[s] && shadow_key[s] == key) begin
                        hit = 1'b1;
                        at  = s;
                    end
                    s = (s + 1) % TABLE_SIZE;
                end
                if (!hit) begin
                    ans.status = STAT_MISSING;
                end else if (mode == MODE_GET) begin
                    ans.value = shadow_value[at];
                    ans.slot  = SLOT_W'(at);
                end else begin
                    shadow_used[at]  = 1'b0;
                    shadow_key[at]   = '0;
                    shadow_value[at] = '0;
                    if (shadow_count > 0)
                        shadow_count--;
                    ans.slot = SLOT_W'(at);
                end
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [KEY_W-1:0] key_at_home(int unsigned home);
        logic [KEY_W-1:0] k;
        k = rand_word();
        while (home_slot(k) != home)
            k = rand_word();
        return k;
    endfunction

    // returns the number of live entries, k is one of them at random
    function automatic int pick_live(output logic [KEY_W-1:0] k);
        int idx [$];
        k = rand_word();
        for (int i = 0; i < TABLE_SIZE; i++)
            if (shadow_used[i])
                idx.push_back(i);
        if (idx.size() > 0)
            k = shadow_key[idx[$urandom_range(idx.size() - 1)]];
        return idx.size();
    endfunction

    task automatic send_request(t_mode mode, logic [KEY_W-1:0] key, logic [DATA_W-1:0] val);
        start      <= 1'b1;
        i_mode     <= mode;
        i_key      <= key;
        i_value_in <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_answers.push_back(apply_table_op(mode, key, val));
    endtask

    task automatic idle(int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic pace();
        if (burst_left <= 0) begin
            idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14));
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    task automatic wait_results_done();
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result, status %0d value %h slot %0d",
                         $time, o_status, o_value_out, o_slot);
                mismatches++;
            end else begin
                oldest_answer = pending_answers.pop_front();
                if (o_status !== oldest_answer.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, oldest_answer.status, o_status);
                    mismatches++;
                end
                if (o_value_out !== oldest_answer.value) begin
                    $display("%0t: value_out expected %h actual %h",
                             $time, oldest_answer.value, o_value_out);
                    mismatches++;
                end
                if (o_slot !== oldest_answer.slot) begin
                    $display("%0t: slot expected %0d actual %0d",
                             $time, oldest_answer.slot, o_slot);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_empty_table();
        send_request(MODE_GET, rand_word(), rand_word());
        send_request(MODE_REMOVE, rand_word(), rand_word());
    endtask

    task automatic test_extreme_fields();
        send_request(MODE_PUT, '0, '0);
        send_request(MODE_PUT, '1, '1);
        send_request(MODE_GET, '0, '1);
        send_request(MODE_GET, '1, '0);
        send_request(MODE_NONE, '1, '1);
        // overwrite of an existing key still counts as an entry
        send_request(MODE_PUT, '0, rand_word());
        send_request(MODE_REMOVE, '1, rand_word());
        send_request(MODE_GET, '1, rand_word());
    endtask

    task automatic test_wraparound();
        logic [KEY_W-1:0] first_key;
        logic [KEY_W-1:0] second_key;
        first_key  = key_at_home(TABLE_SIZE - 1);
        second_key = key_at_home(TABLE_SIZE - 1);
        send_request(MODE_PUT, first_key, rand_word());
        send_request(MODE_PUT, second_key, rand_word());
        send_request(MODE_REMOVE, first_key, rand_word());
        send_request(MODE_GET, second_key, rand_word());
    endtask

    task automatic test_probe_limit();
        logic [KEY_W-1:0] chain [MAX_PROBES + 1];
        int               base;
        bit               clear;
        base  = 8;
        clear = 1'b0;
        while (!clear && base < 48) begin
            clear = 1'b1;
            for (int j = 0; j <= MAX_PROBES; j++)
                if (shadow_used[base + j])
                    clear = 1'b0;
            if (!clear)
                base++;
        end
        for (int i = 0; i <= MAX_PROBES; i++)
            chain[i] = key_at_home(base);
        for (int i = 0; i <= MAX_PROBES; i++)
            send_request(MODE_PUT, chain[i], rand_word());
        // a hole in the chain: lookups skip it, the refused key lands in it
        send_request(MODE_REMOVE, chain[3], rand_word());
        send_request(MODE_GET, chain[MAX_PROBES - 1], rand_word());
        send_request(MODE_PUT, chain[MAX_PROBES], rand_word());
    endtask

    task automatic test_occupancy_limit();
        logic [KEY_W-1:0] k;
        int               guard;
        guard = 0;
        while (shadow_count < TABLE_SIZE / 2 && guard < 200) begin
            pace();
            send_request(MODE_PUT, rand_word(), rand_word());
            guard++;
        end
        send_request(MODE_PUT, rand_word(), rand_word());
        void'(pick_live(k));
        send_request(MODE_PUT, k, rand_word());
        send_request(MODE_GET, k, rand_word());
        wait_results_done();
        guard = 0;
        while (shadow_count > 12 && guard < 200) begin
            void'(pick_live(k));
            pace();
            send_request(MODE_REMOVE, k, rand_word());
            guard++;
        end
    endtask

    task automatic test_random_mix();
        logic [KEY_W-1:0] k;
        int               live;
        int               roll;
        int               put_top;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            live    = pick_live(k);
            roll    = $urandom_range(0, 99);
            put_top = (shadow_count >= 26) ? 25 : 45;
            pace();
            if (roll < 3) begin
                send_request(MODE_NONE, rand_word(), rand_word());
            end else if (roll < put_top) begin
                if ($urandom_range(0, 1))
                    k = key_at_home($urandom_range(40, 43));
                else
                    k = rand_word();
                send_request(MODE_PUT, k, rand_word());
            end else if (roll < put_top + 5) begin
                // overwrites inflate the entry count for good, so keep them rare
                if (live > 0 && shadow_count - live < 8)
                    send_request(MODE_PUT, k, rand_word());
                else
                    send_request(MODE_GET, k, rand_word());
            end else if (roll < put_top + 30) begin
                send_request(MODE_GET, k, rand_word());
            end else if (roll < put_top + 37) begin
                send_request(MODE_GET, key_at_home($urandom_range(40, 43)), rand_word());
            end else if ($urandom_range(0, 5) == 0) begin
                send_request(MODE_REMOVE, key_at_home($urandom_range(40, 43)), rand_word());
            end else begin
                send_request(MODE_REMOVE, k, rand_word());
            end
        end
    endtask

    initial begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        mismatches = 0;
        burst_left = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_extreme_fields();
        wait_results_done();
        test_wraparound();
        test_probe_limit();
        wait_results_done();
        test_occupancy_limit();
        test_random_mix();
        wait_results_done();
        repeat (40) @(posedge i_clk);
        if (pending_answers.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_answers.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/lpht_pkg.sv
sv/lpht_ram.sv
sv/linear_probe_hash_table_top.sv
sv/lpht_checker.sv
dv/linear_probe_hash_table_top_test.sv
